// ===== sv/bpc_pkg.sv =====
// Shared types, constants and channel arithmetic of the blit pixel combiner.
package bpc_pkg;

	// Register index codes on the configuration port
	localparam logic [2:0] REG_MODE         = 3'd0;
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd1;
	localparam logic [2:0] REG_BLEND_AMOUNT = 3'd2;
	localparam logic [2:0] REG_KEY_COLOR_16 = 3'd3;
	localparam logic [2:0] REG_KEY_COLOR_32 = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// Blit modes
	typedef enum logic [3:0] {
		MODE_AND         = 4'd0,
		MODE_OR          = 4'd1,
		MODE_XOR         = 4'd2,
		MODE_INV_COPY    = 4'd3,
		MODE_TRANSPARENT = 4'd4,
		MODE_SRC_ALPHA   = 4'd5,
		MODE_ADDITIVE    = 4'd6,
		MODE_CONST_BLEND = 4'd7,
		MODE_ALPHA_MASK  = 4'd8
	} mode_t;

	// Pixel formats; code three behaves as 32-bit
	localparam logic [1:0] FMT_8  = 2'd0;
	localparam logic [1:0] FMT_16 = 2'd1;
	localparam logic [1:0] FMT_32 = 2'd2;

	localparam logic [31:0] RGB_MASK_32 = 32'h00FF_FFFF;

	// Reset values of the registers
	localparam logic [3:0]  RST_MODE         = 4'd0;
	localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_32;
	localparam logic [7:0]  RST_BLEND_AMOUNT = 8'hFF;
	localparam logic [15:0] RST_KEY_COLOR_16 = 16'hF81F;
	localparam logic [23:0] RST_KEY_COLOR_32 = 24'hFF00FF;

	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  pixel_format;
		logic [7:0]  blend_amount;
		logic [15:0] key_color_16;
		logic [23:0] key_color_32;
	} cfg_t;

	typedef struct packed {
		logic [31:0] result_pixel;
		logic        changed;
	} comb_res_t;

	// Four byte lanes: (s*f + d*(256-f)) >> 8, written as d + (s-d)*f/256
	function automatic logic [31:0] blend32(input logic [31:0] s, input logic [31:0] d,
		input logic [8:0] f);
		logic [31:0]        r;
		logic [7:0]         sc;
		logic [7:0]         dc;
		logic signed [9:0]  diff;
		logic signed [19:0] prod;
		logic signed [19:0] acc;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			sc   = s[i*8 +: 8];
			dc   = d[i*8 +: 8];
			diff = $signed({2'b00, sc}) - $signed({2'b00, dc});
			prod = diff * $signed({1'b0, f});
			acc  = $signed({4'b0000, dc, 8'h00}) + prod;
			r[i*8 +: 8] = acc[15:8];
		end
		return r;
	endfunction

	// One RGB565 field: (s*f + d*(32-f)) >> 5, fields up to six bits wide
	function automatic logic [5:0] blend565_field(input logic [5:0] sc, input logic [5:0] dc,
		input logic [5:0] f);
		logic signed [7:0]  diff;
		logic signed [13:0] prod;
		logic signed [13:0] acc;
		diff = $signed({2'b00, sc}) - $signed({2'b00, dc});
		prod = diff * $signed({1'b0, f});
		acc  = $signed({3'b000, dc, 5'b00000}) + prod;
		return acc[10:5];
	endfunction

	// Scaled source added to destination, saturating per byte
	function automatic logic [31:0] additive32(input logic [31:0] s, input logic [31:0] d,
		input logic [7:0] k);
		logic [31:0] r;
		logic [15:0] p;
		logic [8:0]  c;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			p = s[i*8 +: 8] * k;
			c = {1'b0, p[15:8]} + {1'b0, d[i*8 +: 8]};
			r[i*8 +: 8] = c[8] ? 8'hFF : c[7:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/bpc_cfg_regs.sv =====
// Configuration register file of the blit pixel combiner.
module bpc_cfg_regs import bpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= RST_MODE;
			cfg_q.pixel_format <= RST_PIXEL_FORMAT;
			cfg_q.blend_amount <= RST_BLEND_AMOUNT;
			cfg_q.key_color_16 <= RST_KEY_COLOR_16;
			cfg_q.key_color_32 <= RST_KEY_COLOR_32;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:         cfg_q.mode         <= cfg_wdata[3:0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_wdata[1:0];
				REG_BLEND_AMOUNT: cfg_q.blend_amount <= cfg_wdata[7:0];
				REG_KEY_COLOR_16: cfg_q.key_color_16 <= cfg_wdata[15:0];
				REG_KEY_COLOR_32: cfg_q.key_color_32 <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bpc_combine.sv =====
// Raster-op and blend datapath: one source/destination pair to one result pixel.
module bpc_combine import bpc_pkg::*; (
	input  cfg_t        cfg,
	input  logic [31:0] src,
	input  logic [31:0] dst,
	output comb_res_t   res
);

	logic [1:0]  fmt;
	logic [31:0] wm;
	logic [31:0] s;
	logic [31:0] d;
	logic        key32_hit;
	logic        key16_hit;
	logic [8:0]  amt_p7;
	logic [5:0]  f565;
	logic [5:0]  r565_r;
	logic [5:0]  r565_g;
	logic [5:0]  r565_b;
	logic [31:0] blend_src_a;
	logic [31:0] blend_const;
	logic [31:0] add_res;

	// Format decode and width masking
	assign fmt = (cfg.pixel_format == 2'd3) ? FMT_32 : cfg.pixel_format;
	assign wm  = (fmt == FMT_8) ? 32'h0000_00FF :
	             (fmt == FMT_16) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
	assign s   = src & wm;
	assign d   = dst & wm;

	// Colour key tests
	assign key32_hit = (src[23:0] == cfg.key_color_32);
	assign key16_hit = (s[15:0] == cfg.key_color_16);

	// RGB565 constant blend, factor (k+7)>>3
	assign amt_p7 = {1'b0, cfg.blend_amount} + 9'd7;
	assign f565   = amt_p7[8:3];
	assign r565_r = blend565_field({1'b0, s[15:11]}, {1'b0, d[15:11]}, f565);
	assign r565_g = blend565_field(s[10:5], d[10:5], f565);
	assign r565_b = blend565_field({1'b0, s[4:0]}, {1'b0, d[4:0]}, f565);

	// 32-bit lane arithmetic
	assign blend_src_a = blend32(src, dst, {1'b0, src[31:24]} + 9'd1);
	assign blend_const = blend32(src, dst, {1'b0, cfg.blend_amount} + 9'd1);
	assign add_res     = additive32(src, dst, cfg.blend_amount);

	// Result select by mode
	always_comb begin
		res.result_pixel = d;
		res.changed      = 1'b1;
		unique case (mode_t'(cfg.mode))
			MODE_AND:      res.result_pixel = d & s;
			MODE_OR:       res.result_pixel = d | s;
			MODE_XOR:      res.result_pixel = d ^ s;
			MODE_INV_COPY: res.result_pixel = ~s & wm;
			MODE_TRANSPARENT: begin
				if (fmt == FMT_8) begin
					if (s == 32'd0) res.changed = 1'b0;
					else res.result_pixel = s;
				end else if (fmt == FMT_16) begin
					if (key16_hit) res.changed = 1'b0;
					else res.result_pixel = s;
				end else begin
					// opaque copy drops the alpha byte
					if (key32_hit) res.changed = 1'b0;
					else res.result_pixel = src & RGB_MASK_32;
				end
			end
			MODE_SRC_ALPHA: res.result_pixel = blend_src_a;
			MODE_ADDITIVE: begin
				if (key32_hit) begin
					res.result_pixel = dst;
					res.changed      = 1'b0;
				end else begin
					res.result_pixel = add_res;
				end
			end
			MODE_CONST_BLEND: begin
				if (fmt == FMT_16) begin
					if (key16_hit) res.changed = 1'b0;
					else res.result_pixel = {16'h0000, r565_r[4:0], r565_g, r565_b[4:0]};
				end else if (fmt == FMT_32) begin
					if (key32_hit) res.changed = 1'b0;
					else res.result_pixel = blend_const;
				end else begin
					// no 8-bit blend: destination kept
					res.changed = 1'b0;
				end
			end
			MODE_ALPHA_MASK: res.result_pixel = (dst & RGB_MASK_32) | {src[7:0], 24'h000000};
			default: res.changed = 1'b0;
		endcase
	end

endmodule

// ===== sv/blit_pixel_combiner.sv =====
// Top level of the blit pixel combiner: config registers, input stage, result stage.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------------
//   in       | in_valid / in_ready     | src_pixel, dst_pixel, row_end, block_end
//   out      | out_valid / out_ready   | result_pixel, changed, row_done, block_done
//   cfg      | cfg_wr_en (no wait)     | cfg_index, cfg_wdata
//
// One request per cycle sustained while out is ready; results pass the input register, then the result register.
// The whole combine is one combinational pass through bpc_combine between the stages.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on out backs up through both stages; each stage refills in the cycle it drains.
module blit_pixel_combiner import bpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            src_pixel,
	input  logic [31:0]            dst_pixel,
	input  logic                   row_end,
	input  logic                   block_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            result_pixel,
	output logic                   changed,
	output logic                   row_done,
	output logic                   block_done
);

	cfg_t        cfg;
	comb_res_t   comb_res;
	logic        valid_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic        row_s1;
	logic        blk_s1;
	logic        valid_s2;
	comb_res_t   res_s2;
	logic        row_s2;
	logic        blk_s2;
	logic        s2_free;
	logic        adv_s1;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bpc_combine u_combine (
		.cfg (cfg),
		.src (src_s1),
		.dst (dst_s1),
		.res (comb_res)
	);

	// Stage flow control
	assign s2_free  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			src_s1 <= src_pixel;
			dst_s1 <= dst_pixel;
			row_s1 <= row_end;
			blk_s1 <= block_end;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= comb_res;
			row_s2 <= row_s1;
			blk_s2 <= blk_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign result_pixel = res_s2.result_pixel;
	assign changed      = res_s2.changed;
	assign row_done     = row_s2;
	assign block_done   = blk_s2;

	// Checks
	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_held_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(src_s1) && $stable(dst_s1))
		else $error("stalled input stage lost its request");

	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cfg.mode > MODE_ALPHA_MASK |=> !changed)
		else $error("unused mode changed the destination");

	a_alpha_mask: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cfg.mode == MODE_ALPHA_MASK |=>
		changed && result_pixel[23:0] == $past(dst_s1[23:0]))
		else $error("alpha mask altered the colour bytes");

	a_eight_bit: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cfg.pixel_format == FMT_8 && cfg.mode <= MODE_TRANSPARENT |=>
		result_pixel[31:8] == 24'd0)
		else $error("eight-bit result not zero-extended");

endmodule
